// ===== hdl/sgfc_pkg.sv =====
// Shared types, constants and lookup tables for the five-channel sound generator.
// No dependencies.
`timescale 1ns / 1ps
package sgfc_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_IDLE  = 2'd3;

    localparam logic [4:0] ADDR_DELTA_CTRL  = 5'h10;
    localparam logic [4:0] ADDR_DELTA_LOAD  = 5'h11;
    localparam logic [4:0] ADDR_DELTA_ADDR  = 5'h12;
    localparam logic [4:0] ADDR_DELTA_LEN   = 5'h13;
    localparam logic [4:0] ADDR_STATUS      = 5'h15;
    localparam logic [4:0] ADDR_FRAME       = 5'h17;

    localparam logic [31:0] DUTY_BITS    = 32'h9F786040;
    localparam logic [13:0] FRAME_DIVIDE = 14'd14915;

    typedef struct packed {
        logic [1:0] cmd;
        logic [4:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] sample_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [3:0]  pulse_one_level;
        logic [3:0]  pulse_two_level;
        logic [3:0]  triangle_level;
        logic [3:0]  noise_level;
        logic [6:0]  delta_level;
        logic [6:0]  direct_level;
        logic        frame_flag;
        logic        delta_irq;
        logic [15:0] fetch_address;
        logic        fetch_used;
    } t_out;

    function automatic logic [7:0] len_lookup(input logic [4:0] i);
        logic [7:0] v;
        unique case (i)
            5'd0: v = 8'd10;   5'd1: v = 8'd254;  5'd2: v = 8'd20;   5'd3: v = 8'd2;
            5'd4: v = 8'd40;   5'd5: v = 8'd4;    5'd6: v = 8'd80;   5'd7: v = 8'd6;
            5'd8: v = 8'd160;  5'd9: v = 8'd8;    5'd10: v = 8'd60;  5'd11: v = 8'd10;
            5'd12: v = 8'd14;  5'd13: v = 8'd12;  5'd14: v = 8'd26;  5'd15: v = 8'd14;
            5'd16: v = 8'd12;  5'd17: v = 8'd16;  5'd18: v = 8'd24;  5'd19: v = 8'd18;
            5'd20: v = 8'd48;  5'd21: v = 8'd20;  5'd22: v = 8'd96;  5'd23: v = 8'd22;
            5'd24: v = 8'd192; 5'd25: v = 8'd24;  5'd26: v = 8'd72;  5'd27: v = 8'd26;
            5'd28: v = 8'd16;  5'd29: v = 8'd28;  5'd30: v = 8'd32;  default: v = 8'd30;
        endcase
        return v;
    endfunction

    function automatic logic [10:0] noise_lookup(input logic [3:0] i);
        logic [10:0] v;
        unique case (i)
            4'd0: v = 11'd2;    4'd1: v = 11'd4;    4'd2: v = 11'd8;    4'd3: v = 11'd16;
            4'd4: v = 11'd32;   4'd5: v = 11'd48;   4'd6: v = 11'd64;   4'd7: v = 11'd80;
            4'd8: v = 11'd101;  4'd9: v = 11'd127;  4'd10: v = 11'd190; 4'd11: v = 11'd254;
            4'd12: v = 11'd381; 4'd13: v = 11'd508; 4'd14: v = 11'd1017;
            default: v = 11'd2034;
        endcase
        return v;
    endfunction

    function automatic logic [10:0] delta_lookup(input logic [3:0] i);
        logic [10:0] v;
        unique case (i)
            4'd0: v = 11'd428;  4'd1: v = 11'd380;  4'd2: v = 11'd340;  4'd3: v = 11'd320;
            4'd4: v = 11'd286;  4'd5: v = 11'd254;  4'd6: v = 11'd226;  4'd7: v = 11'd214;
            4'd8: v = 11'd190;  4'd9: v = 11'd160;  4'd10: v = 11'd142; 4'd11: v = 11'd128;
            4'd12: v = 11'd106; 4'd13: v = 11'd84;  4'd14: v = 11'd72;
            default: v = 11'd54;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/sgfc_stream_if.sv =====
// Valid/ready channel interface with a parameterized payload type.
// No dependencies.
`timescale 1ns / 1ps
interface sgfc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sgfc_core.sv =====
// Sound generator state and per-transaction update: register file, frame
// sequencer and channel waveforms. Depends on sgfc_pkg.
`timescale 1ns / 1ps
module sgfc_core
    import sgfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_in  i_item,
    output t_out o_res
);

    logic [7:0]  r_ctrl [20];
    logic [10:0] r_period [5];
    logic [12:0] r_timer [5];
    logic [11:0] r_length [5];
    logic [6:0]  r_linear [5];
    logic [3:0]  r_env [5];
    logic [3:0]  r_envdiv [5];
    logic [2:0]  r_swdiv [5];
    logic [4:0]  r_phase [5];
    logic [14:0] r_shift [5];
    logic [6:0]  r_level [5];
    logic [4:0]  r_enabled;
    logic [14:0] r_daddr;
    logic [13:0] r_frac;
    logic [2:0]  r_fstep;
    logic        r_five;
    logic        r_inhibit;
    logic        r_firq;
    logic        r_dirq;
    logic [6:0]  r_direct;

    logic [7:0]  n_ctrl [20];
    logic [10:0] n_period [5];
    logic [12:0] n_timer [5];
    logic [11:0] n_length [5];
    logic [6:0]  n_linear [5];
    logic [3:0]  n_env [5];
    logic [3:0]  n_envdiv [5];
    logic [2:0]  n_swdiv [5];
    logic [4:0]  n_phase [5];
    logic [14:0] n_shift [5];
    logic [6:0]  n_level [5];
    logic [4:0]  n_enabled;
    logic [14:0] n_daddr;
    logic [13:0] n_frac;
    logic [2:0]  n_fstep;
    logic        n_five;
    logic        n_inhibit;
    logic        n_firq;
    logic        n_dirq;
    logic [6:0]  n_direct;

    always_comb begin
        logic [1:0]  cmd;
        logic [4:0]  a;
        logic [7:0]  d;
        logic [7:0]  rd;
        logic [6:0]  lv [5];
        logic        used;
        logic [14:0] fr;
        logic [2:0]  st;
        logic        half;
        logic        full;
        logic        halt;
        logic [11:0] wl;
        logic [11:0] sft;
        logic [12:0] twl;
        logic [3:0]  vol;
        logic [4:0]  bidx;
        logic [4:0]  p;
        logic [14:0] h;
        logic        fb;
        logic [7:0]  r0;
        logic [7:0]  r1;
        logic [7:0]  r2;
        logic [7:0]  r3;
        logic [2:0]  ch;
        logic [14:0] dstart;
        logic [14:0] nxt;
        cmd = i_item.cmd;
        a   = i_item.reg_addr;
        d   = i_item.write_data;
        rd  = d;
        used = 1'b0;
        for (int c = 0; c < 5; c++) lv[c] = '0;
        n_ctrl = r_ctrl; n_period = r_period; n_timer = r_timer; n_length = r_length;
        n_linear = r_linear; n_env = r_env; n_envdiv = r_envdiv; n_swdiv = r_swdiv;
        n_phase = r_phase; n_shift = r_shift; n_level = r_level; n_enabled = r_enabled;
        n_daddr = r_daddr; n_frac = r_frac; n_fstep = r_fstep; n_five = r_five;
        n_inhibit = r_inhibit; n_firq = r_firq; n_dirq = r_dirq; n_direct = r_direct;
        fr = '0; st = '0; half = 1'b0; full = 1'b0; halt = 1'b0; wl = '0; sft = '0;
        twl = '0; vol = '0; bidx = '0; p = '0; h = '0; fb = 1'b0;
        r0 = '0; r1 = '0; r2 = '0; r3 = '0; ch = '0;
        dstart = 15'(({8'd0, r_ctrl[16]} | 16'h0300) << 6);

        if (cmd == CMD_WRITE) begin
            if (a < 5'h10) begin
                ch = {1'b0, a[3:2]};
                unique case (a[1:0])
                    2'd0: n_ctrl[{ch, 2'b00}] = d;
                    2'd1: begin
                        n_ctrl[{ch, 2'b01}] = d;
                        n_swdiv[ch] = d[6:4];
                    end
                    2'd2: begin
                        n_ctrl[{ch, 2'b10}] = d;
                        n_period[ch] = {r_period[ch][10:8], d};
                    end
                    default: begin
                        n_ctrl[{ch, 2'b11}] = d;
                        n_period[ch] = {d[2:0], r_period[ch][7:0]};
                        if (r_enabled[ch]) n_length[ch] = {4'd0, len_lookup(d[7:3])};
                        n_linear[ch] = r_ctrl[{ch, 2'b00}][6:0];
                        n_envdiv[ch] = r_ctrl[{ch, 2'b00}][3:0];
                        n_env[ch] = 4'hF;
                        if (!a[3]) n_phase[ch] = '0;
                    end
                endcase
            end else begin
                priority case (a)
                    ADDR_DELTA_CTRL: begin
                        n_ctrl[19] = d;
                        n_period[4] = delta_lookup(d[3:0]);
                    end
                    ADDR_DELTA_LOAD: n_direct = d[6:0];
                    ADDR_DELTA_ADDR: begin
                        n_ctrl[16] = d;
                        n_daddr = 15'(({8'd0, d} | 16'h0300) << 6);
                    end
                    ADDR_DELTA_LEN: begin
                        n_ctrl[17] = d;
                        n_length[4] = {d, 4'h1};
                    end
                    ADDR_STATUS: begin
                        n_dirq = 1'b0;
                        for (int c = 0; c < 5; c++) begin
                            n_enabled[c] = d[c];
                            if (!d[c]) n_length[c] = '0;
                            else if (c == 4 && r_length[4] == '0)
                                n_length[4] = {r_ctrl[17], 4'h1};
                        end
                    end
                    ADDR_FRAME: begin
                        n_five = d[7];
                        n_inhibit = d[6];
                        n_frac = '0;
                        n_fstep = '0;
                        if (d[6]) begin
                            n_firq = 1'b0;
                            n_dirq = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (cmd == CMD_READ) begin
            if (a == ADDR_STATUS) begin
                rd = '0;
                for (int c = 0; c < 5; c++) rd[c] = (r_length[c] != '0);
                rd[6] = r_firq;
                rd[7] = r_dirq;
                n_firq = 1'b0;
            end
        end else if (cmd == CMD_TICK) begin
            rd = '0;
            // frame sequencer
            fr = {1'b0, r_frac} + 15'd2;
            if (fr >= {1'b0, FRAME_DIVIDE}) begin
                n_frac = 14'(fr - {1'b0, FRAME_DIVIDE});
                st = r_fstep + 3'd1;
                if ({1'b0, st} >= (4'd4 + {3'd0, r_five})) st = '0;
                n_fstep = st;
                if (!r_inhibit && !r_five && st == '0) n_firq = 1'b1;
                half = (st & 3'd5) == 3'd1;
                full = st < 3'd4;
                for (int c = 0; c < 4; c++) begin
                    r0 = r_ctrl[c*4];
                    r1 = r_ctrl[c*4+1];
                    halt = (c == 2) ? r0[7] : r0[5];
                    if (half && r_length[c] != '0 && !halt) n_length[c] = r_length[c] - 12'd1;
                    if (half && c < 2) begin
                        if (r_swdiv[c] == '0) begin
                            n_swdiv[c] = r1[6:4];
                            if (r_period[c] >= 11'd8 && r1[7] && r1[2:0] != '0) begin
                                sft = {1'b0, r_period[c] >> r1[2:0]};
                                if (r1[3]) wl = {1'b0, r_period[c]} - sft
                                              - ((c == 0) ? 12'd1 : 12'd0);
                                else wl = {1'b0, r_period[c]} + sft;
                                if (wl < 12'h800) n_period[c] = wl[10:0];
                            end
                        end else n_swdiv[c] = r_swdiv[c] - 3'd1;
                    end
                    if (full && c == 2) begin
                        if (r0[7]) n_linear[c] = r0[6:0];
                        else if (r_linear[c] != '0) n_linear[c] = r_linear[c] - 7'd1;
                    end
                    if (full && c != 2) begin
                        if (r_envdiv[c] == '0) begin
                            n_envdiv[c] = r0[3:0];
                            if (r_env[c] != '0 || r0[5]) n_env[c] = r_env[c] - 4'd1;
                        end else n_envdiv[c] = r_envdiv[c] - 4'd1;
                    end
                end
            end else n_frac = fr[13:0];

            // channel timers
            for (int c = 0; c < 4; c++) begin
                r0 = n_ctrl[c*4];
                r2 = n_ctrl[c*4+2];
                if (!r_enabled[c]) lv[c] = 7'd8;
                else begin
                    if (c == 3) twl = {1'b0, noise_lookup(r2[3:0]), 1'b0};
                    else if (c == 2) twl = 13'({2'b0, n_period[c]} + 13'd1);
                    else twl = 13'(({2'b0, n_period[c]} + 13'd1) << 1);
                    vol = (n_length[c] != '0) ? (r0[4] ? r0[3:0] : n_env[c]) : 4'd0;
                    lv[c] = r_level[c];
                    if (r_timer[c] != '0) n_timer[c] = r_timer[c] - 13'd1;
                    else begin
                        n_timer[c] = twl;
                        if (c < 2) begin
                            if (twl < 13'd8) n_level[c] = 7'd8;
                            else begin
                                bidx = {r0[7:6], 3'b000} + {2'b00, r_phase[c][2:0]};
                                n_phase[c] = r_phase[c] + 5'd1;
                                n_level[c] = DUTY_BITS[bidx] ? {3'd0, vol} : 7'd0;
                            end
                        end else if (c == 2) begin
                            if (n_length[c] == '0 || n_linear[c] == '0 || twl < 13'd3)
                                n_level[c] = 7'd8;
                            else begin
                                p = r_phase[c] + 5'd1;
                                n_phase[c] = p;
                                n_level[c] = {3'd0, p[3:0] ^ {4{p[4]}}};
                            end
                        end else begin
                            h = (r_shift[c] == '0) ? 15'd1 : r_shift[c];
                            fb = h[0] ^ (r2[7] ? h[6] : h[1]);
                            h = {fb, h[14:1]};
                            n_shift[c] = h;
                            n_level[c] = h[0] ? 7'd0 : {3'd0, vol};
                        end
                        lv[c] = n_level[c];
                    end
                end
            end

            // delta channel
            r3 = n_ctrl[19];
            if (!r_enabled[4]) lv[4] = r_linear[4];
            else begin
                lv[4] = r_level[4];
                if (r_timer[4] != '0) n_timer[4] = r_timer[4] - 13'd1;
                else begin
                    n_timer[4] = {2'b0, n_period[4]} + 13'd1;
                    p = r_phase[4];
                    if (p == '0) begin
                        if (r_length[4] == '0 && r3[6]) begin
                            n_length[4] = {n_ctrl[17], 4'h1};
                            n_daddr = dstart;
                        end
                        p = 5'd8;
                        if (n_length[4] != '0) begin
                            n_shift[4] = {7'd0, i_item.sample_byte};
                            n_daddr = n_daddr + 15'd1;
                            n_length[4] = n_length[4] - 12'd1;
                            used = 1'b1;
                        end else if (r3[7]) begin
                            n_dirq = 1'b1;
                            n_enabled[4] = 1'b1;
                        end else n_enabled[4] = 1'b0;
                    end
                    if (p != '0) p = p - 5'd1;
                    n_phase[4] = p;
                    if (n_enabled[4]) begin
                        if (n_shift[4][{1'b0, 3'd7 - p[2:0]}]) begin
                            if (r_linear[4] < 7'd126) n_linear[4] = r_linear[4] + 7'd2;
                        end else if (r_linear[4] >= 7'd2) n_linear[4] = r_linear[4] - 7'd2;
                    end
                    n_level[4] = n_linear[4];
                    lv[4] = n_linear[4];
                end
            end
        end

        nxt = n_daddr;
        if (n_length[4] == '0 && n_ctrl[19][6])
            nxt = 15'(({8'd0, n_ctrl[16]} | 16'h0300) << 6);

        o_res.read_data       = rd;
        o_res.pulse_one_level = lv[0][3:0];
        o_res.pulse_two_level = lv[1][3:0];
        o_res.triangle_level  = lv[2][3:0];
        o_res.noise_level     = lv[3][3:0];
        o_res.delta_level     = lv[4];
        o_res.direct_level    = n_direct;
        o_res.frame_flag      = n_firq;
        o_res.delta_irq       = n_dirq;
        o_res.fetch_address   = {1'b1, nxt};
        o_res.fetch_used      = used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 20; i++) r_ctrl[i] <= '0;
            for (int c = 0; c < 5; c++) begin
                r_period[c] <= '0; r_timer[c] <= '0; r_length[c] <= '0;
                r_linear[c] <= '0; r_env[c] <= '0; r_envdiv[c] <= '0;
                r_swdiv[c] <= '0; r_phase[c] <= '0; r_shift[c] <= '0;
                r_level[c] <= '0;
            end
            r_enabled <= '0; r_daddr <= '0; r_frac <= '0; r_fstep <= '0;
            r_five <= 1'b0; r_inhibit <= 1'b0; r_firq <= 1'b0; r_dirq <= 1'b0;
            r_direct <= '0;
        end else if (i_en) begin
            r_ctrl <= n_ctrl; r_period <= n_period; r_timer <= n_timer;
            r_length <= n_length; r_linear <= n_linear; r_env <= n_env;
            r_envdiv <= n_envdiv; r_swdiv <= n_swdiv; r_phase <= n_phase;
            r_shift <= n_shift; r_level <= n_level; r_enabled <= n_enabled;
            r_daddr <= n_daddr; r_frac <= n_frac; r_fstep <= n_fstep;
            r_five <= n_five; r_inhibit <= n_inhibit; r_firq <= n_firq;
            r_dirq <= n_dirq; r_direct <= n_direct;
        end
    end

endmodule

// ===== hdl/sound_generator_five_channel.sv =====
// Five-channel sound generator top level: input register, core, result register.
// Throughput: one transaction per cycle unless the result register is held by
// o_out.ready back-pressure, set by the single-pass core update between the two registers.
// Reset: synchronous active-low i_rst_n clears all channel and sequencer state.
// Depends on sgfc_pkg, sgfc_stream_if, sgfc_core.
`timescale 1ns / 1ps
module sound_generator_five_channel
    import sgfc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    sgfc_stream_if.sink    i_in,
    sgfc_stream_if.source  o_out
);

    logic r_in_vld;
    t_in  r_in;
    logic r_out_vld;
    t_out r_out;
    t_out w_res;
    logic w_adv;
    logic w_in_rdy;

    assign w_adv    = r_in_vld && (!r_out_vld || o_out.ready);
    assign w_in_rdy = !r_in_vld || w_adv;
    assign i_in.ready = w_in_rdy;

    sgfc_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_item (r_in),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_rdy) r_in_vld <= i_in.valid;
            if (w_adv) r_out_vld <= 1'b1;
            else if (o_out.ready) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_rdy && i_in.valid) r_in <= i_in.data;
        if (w_adv) r_out <= w_res;
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule
